FILE: rtl/core/mlbc_pkg.sv
// Package for the multi-LED blink controller.
// Holds the action and mode codes, field widths and defaults.
// It has no dependencies; every other file of the block imports it.
`default_nettype none

package mlbc_pkg;

  // Field widths of the input and result transactions.
  localparam int ActionW   = 2;
  localparam int IndexW    = 4;
  localparam int ModeW     = 2;
  localparam int IntervalW = 16;
  localparam int ElapsedW  = 16;
  localparam int CountW    = 32;
  localparam int VisW      = 4;

  // Parameter defaults and limits.
  localparam int NumLedsDefault = 4;
  localparam int MaxLeds        = 16;

  // Action codes.
  localparam logic [ActionW-1:0] ACT_SET_MODE = 2'd0;
  localparam logic [ActionW-1:0] ACT_TICK     = 2'd1;
  localparam logic [ActionW-1:0] ACT_QUERY    = 2'd2;

  // Mode codes; any other code darkens the LED.
  localparam logic [ModeW-1:0] MODE_OFF   = 2'd0;
  localparam logic [ModeW-1:0] MODE_ON    = 2'd1;
  localparam logic [ModeW-1:0] MODE_BLINK = 2'd2;

  // Interval used when a blink request gives zero, and reset values.
  localparam logic [IntervalW-1:0] DEFAULT_INTERVAL = 16'd500;
  localparam logic [VisW-1:0]      MASK_RESET       = 4'hF;

  // Result of one pass of the shared counter step unit.
  typedef struct packed {
    logic [CountW-1:0] count;
    logic              toggle;
  } step_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/mlbc_in_if.sv
// Input channel of the multi-LED blink controller: valid, ready and payload.
// Depends on mlbc_pkg for the field widths.
`default_nettype none

interface mlbc_in_if;
  import mlbc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ActionW-1:0]   action;
  logic [IndexW-1:0]    led_index;
  logic [ModeW-1:0]     new_mode;
  logic [IntervalW-1:0] blink_ms;
  logic [ElapsedW-1:0]  tick_ms;

  modport source (output valid, action, led_index, new_mode, blink_ms, tick_ms,
                  input ready);
  modport sink (input valid, action, led_index, new_mode, blink_ms, tick_ms,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mlbc_out_if.sv
// Result channel of the multi-LED blink controller: valid, ready and payload.
// Depends on mlbc_pkg for the field widths.
`default_nettype none

interface mlbc_out_if;
  import mlbc_pkg::*;

  logic            valid;
  logic            ready;
  logic [VisW-1:0] pin_levels;
  logic [VisW-1:0] lit_bits;
  logic            queried_on;
  logic            status;

  modport source (output valid, pin_levels, lit_bits, queried_on, status,
                  input ready);
  modport sink (input valid, pin_levels, lit_bits, queried_on, status,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mlbc_step.sv
// Shared counter step unit: saturating add of elapsed time, then a
// compare and subtract against the blink interval. Depends on mlbc_pkg.
`default_nettype none

module mlbc_step (
  input  wire logic [mlbc_pkg::CountW-1:0]    count_in,
  input  wire logic [mlbc_pkg::ElapsedW-1:0]  elapsed,
  input  wire logic [mlbc_pkg::IntervalW-1:0] interval,
  output mlbc_pkg::step_res_t                 res
);
  import mlbc_pkg::*;

  logic [CountW:0]   sum;
  logic [CountW-1:0] sat;
  logic [CountW:0]   diff;

  // Add with saturation at the counter's full scale.
  assign sum = {1'b0, count_in} + {(CountW + 1 - ElapsedW)'(1'b0), elapsed};
  assign sat = sum[CountW] ? {CountW{1'b1}} : sum[CountW-1:0];

  // A subtraction without borrow means the interval has been reached.
  assign diff = {1'b0, sat} - {(CountW + 1 - IntervalW)'(1'b0), interval};

  assign res = {(diff[CountW] ? sat : diff[CountW-1:0]), ~diff[CountW]};
endmodule

`default_nettype wire

FILE: rtl/core/multi_led_blink_controller_unit.sv
// Multi-LED blink controller: top level with sequencer and LED state.
// A set_mode or query passes through the RUN and FIN states before the result
// handshake; a rejected index, a zero tick or an unknown action goes straight
// to FIN; a tick stays in RUN until every LED is visited, since the one shared
// step unit visits one LED per cycle. A new transaction is taken only once the
// result is gone.
// Reset (rst_n low, synchronous): all LEDs off, intervals 500, mask all ones.
// Depends on mlbc_pkg, mlbc_in_if, mlbc_out_if and mlbc_step.
`default_nettype none

module multi_led_blink_controller_unit #(
  parameter int NUM_LEDS = mlbc_pkg::NumLedsDefault
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  mlbc_in_if.sink                        in_chan,
  mlbc_out_if.source                     out_chan,
  input  wire logic                      cfg_we,
  input  wire logic [mlbc_pkg::VisW-1:0] cfg_wdata
);
  import mlbc_pkg::*;

  localparam int IdxW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

  // Sequencer state codes.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [IdxW-1:0] cnt_r, cnt_nxt;

  // Latched transaction fields.
  logic [ActionW-1:0]   act_r;
  logic [ModeW-1:0]     mode_in_r;
  logic [IntervalW-1:0] ivl_in_r;
  logic [ElapsedW-1:0]  el_in_r;
  logic                 status_r;

  // Per-LED state.
  logic [ModeW-1:0]     led_mode_r [NUM_LEDS];
  logic [IntervalW-1:0] interval_r [NUM_LEDS];
  logic [CountW-1:0]    count_r    [NUM_LEDS];
  logic [NUM_LEDS-1:0]  lit_r;
  logic [VisW-1:0]      mask_r;

  // Result register.
  logic            out_valid_r;
  logic [VisW-1:0] out_pins_r;
  logic [VisW-1:0] out_lits_r;
  logic            out_queried_r;
  logic            out_status_r;

  logic          accept;
  logic          idx_ok;
  logic          last_led;
  logic [MaxLeds-1:0] lit_ext;
  logic [MaxLeds-1:0] exist_ext;
  logic [VisW-1:0]    lit_vis;
  logic [VisW-1:0]    pin_vis;
  step_res_t     step_res;

  assign in_chan.ready = (state_r == ST_IDLE) && !out_valid_r;
  assign accept        = in_chan.valid && in_chan.ready;
  assign idx_ok        = {1'b0, in_chan.led_index} < (IndexW + 1)'(NUM_LEDS);
  assign last_led      = cnt_r == IdxW'(NUM_LEDS - 1);

  // Shared step unit works on the LED the counter points at.
  mlbc_step u_step (
    .count_in (count_r[cnt_r]),
    .elapsed  (el_in_r),
    .interval (interval_r[cnt_r]),
    .res      (step_res)
  );

  // Sequencer next state and LED counter.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if ((in_chan.action == ACT_SET_MODE || in_chan.action == ACT_QUERY) && idx_ok) begin
            cnt_nxt   = in_chan.led_index[IdxW-1:0];
            state_nxt = ST_RUN;
          end else if (in_chan.action == ACT_TICK && in_chan.tick_ms != '0) begin
            cnt_nxt   = '0;
            state_nxt = ST_RUN;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_RUN: begin
        if (act_r != ACT_TICK || last_led) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + IdxW'(1);
        end
      end
      ST_FIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Capture the transaction fields on acceptance.
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r     <= in_chan.action;
      mode_in_r <= in_chan.new_mode;
      ivl_in_r  <= in_chan.blink_ms;
      el_in_r   <= in_chan.tick_ms;
      status_r  <= (in_chan.action == ACT_SET_MODE || in_chan.action == ACT_QUERY) && !idx_ok;
    end
  end

  // Active-level mask register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= MASK_RESET;
    end else if (cfg_we) begin
      mask_r <= cfg_wdata;
    end
  end

  // LED state: set_mode reprograms one LED, a tick steps each blinking LED.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        led_mode_r[i] <= MODE_OFF;
        interval_r[i] <= DEFAULT_INTERVAL;
        count_r[i]    <= '0;
      end
      lit_r <= '0;
    end else if (state_r == ST_RUN) begin
      if (act_r == ACT_SET_MODE) begin
        led_mode_r[cnt_r] <= mode_in_r;
        count_r[cnt_r]    <= '0;
        if (mode_in_r == MODE_BLINK) begin
          interval_r[cnt_r] <= (ivl_in_r != '0) ? ivl_in_r : DEFAULT_INTERVAL;
        end
        lit_r[cnt_r] <= (mode_in_r == MODE_ON) || (mode_in_r == MODE_BLINK);
      end else if (act_r == ACT_TICK && led_mode_r[cnt_r] == MODE_BLINK) begin
        count_r[cnt_r] <= step_res.count;
        if (step_res.toggle) begin
          lit_r[cnt_r] <= ~lit_r[cnt_r];
        end
      end
    end
  end

  // Visible LEDs and their pin levels after polarity.
  assign lit_ext   = MaxLeds'(lit_r);
  assign exist_ext = MaxLeds'({NUM_LEDS{1'b1}});
  assign lit_vis   = lit_ext[VisW-1:0];
  assign pin_vis   = (lit_vis & mask_r) | (~lit_vis & ~mask_r & exist_ext[VisW-1:0]);

  // Result register: loaded at the end of the sequence, freed on handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN) begin
      out_pins_r    <= pin_vis;
      out_lits_r    <= lit_vis;
      out_status_r  <= status_r;
      out_queried_r <= (act_r == ACT_SET_MODE || act_r == ACT_QUERY) && !status_r
                       && lit_r[cnt_r];
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.pin_levels = out_pins_r;
  assign out_chan.lit_bits   = out_lits_r;
  assign out_chan.queried_on = out_queried_r;
  assign out_chan.status     = out_status_r;
endmodule

`default_nettype wire
